>>> rtl/itla_pkg.sv
// ----------------------------------------------------------------------------
// itla_pkg
// Shared types and constants of the timestamp latency accumulator.
// ----------------------------------------------------------------------------
package itla_pkg;

    localparam int unsigned POS_W       = 7;
    localparam int unsigned ETYPE_W     = 16;
    localparam int unsigned IHL_W       = 4;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned GOT_W       = 3;
    localparam int unsigned TOTAL_W     = 64;

    localparam logic [POS_W-1:0]   POS_MAX        = 7'd127;
    localparam logic [POS_W-1:0]   POS_ETYPE_HI   = 7'd12;
    localparam logic [POS_W-1:0]   POS_ETYPE_LO   = 7'd13;
    localparam logic [POS_W-1:0]   ETH_HDR_BYTES  = 7'd14;
    localparam logic [GOT_W-1:0]   STAMP_BYTES    = 3'd4;
    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;

    typedef struct packed {
        logic               ok;
        logic [STAMP_W-1:0] stamp;
    } t_frame_result;

endpackage

>>> rtl/itla_frame_parser.sv
// ----------------------------------------------------------------------------
// itla_frame_parser
// Per-frame byte tracking: ethertype, IHL and timestamp word capture, with
// the frame verdict formed on the last byte.
// ----------------------------------------------------------------------------
module itla_frame_parser
    import itla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic [ETYPE_W-1:0]  i_match_ethertype,
    output t_frame_result       o_result
);

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [ETYPE_W-1:0] r_etype, n_etype;
    logic [IHL_W-1:0]   r_ihl,   n_ihl;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic [GOT_W-1:0]   r_got,   n_got;

    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   stop;
    logic               take;

    always_comb begin
        n_etype = r_etype;
        n_ihl   = r_ihl;
        if (r_pos == POS_ETYPE_HI) begin
            n_etype = {i_byte, r_etype[7:0]};
        end else if (r_pos == POS_ETYPE_LO) begin
            n_etype = {r_etype[15:8], i_byte};
        end else if (r_pos == ETH_HDR_BYTES) begin
            n_ihl = i_byte[IHL_W-1:0];
        end

        start = ETH_HDR_BYTES + {1'b0, n_ihl, 2'b00};
        stop  = start + 7'd4;
        take  = (r_pos != POS_MAX) && (r_pos >= start) && (r_pos < stop)
                && (r_got < STAMP_BYTES);

        n_stamp = take ? {r_stamp[STAMP_W-9:0], i_byte} : r_stamp;
        n_got   = take ? r_got + 3'd1 : r_got;
        n_pos   = (r_pos == POS_MAX) ? r_pos : r_pos + 7'd1;

        o_result.ok    = (n_etype == i_match_ethertype) && (n_got == STAMP_BYTES);
        o_result.stamp = n_stamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_etype <= '0;
            r_ihl   <= '0;
            r_stamp <= '0;
            r_got   <= '0;
        end else if (i_fire) begin
            if (i_last) begin
                r_pos   <= '0;
                r_etype <= '0;
                r_ihl   <= '0;
                r_stamp <= '0;
                r_got   <= '0;
            end else begin
                r_pos   <= n_pos;
                r_etype <= n_etype;
                r_ihl   <= n_ihl;
                r_stamp <= n_stamp;
                r_got   <= n_got;
            end
        end
    end

endmodule

>>> rtl/ipv4_timestamp_latency_accumulator_core.sv
// ----------------------------------------------------------------------------
// ipv4_timestamp_latency_accumulator_core
// Counts frames of a chosen ethertype and sums the timestamp word they carry.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per beat (i_data_byte, i_last_byte) under
// i_in_valid / o_in_stall. Output channel: one result beat per frame, on the
// frame's last byte, under o_out_valid / i_out_stall. A beat moves at an edge
// where valid is high and stall is low.
// A last byte is held in the input register, and its verdict is registered into the result register.
// Throughput: one byte per cycle unless a last byte waits for the result slot;
// set by the input register feeding the parser and the 64-bit total adders into the result register.
// When the receiver stalls, the result and both totals hold; the input side
// keeps taking non-last bytes and stalls only on a last byte waiting for the
// result slot.
// i_cfg_wr_en writes the match ethertype; write it only while idle.
// Synchronous reset (i_rst_n low) clears the frame state, both totals and the
// valid flags, and sets the match ethertype to 0x0800.
// ----------------------------------------------------------------------------
module ipv4_timestamp_latency_accumulator_core
    import itla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [ETYPE_W-1:0]  i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_frame_accepted,
    output logic [STAMP_W-1:0]  o_latency_value,
    output logic [TOTAL_W-1:0]  o_packet_total,
    output logic [TOTAL_W-1:0]  o_latency_total
);

    logic [ETYPE_W-1:0] r_match;
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               r_out_valid;
    logic               r_out_ok;
    logic [STAMP_W-1:0] r_out_lat;
    logic [TOTAL_W-1:0] r_pkt_total;
    logic [TOTAL_W-1:0] r_lat_total;

    logic               out_free;
    logic               s1_fire;
    logic               s1_result;
    logic               in_fire;
    t_frame_result      res;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign s1_fire   = r_in_valid && (!r_in_last || out_free);
    assign s1_result = s1_fire && r_in_last;
    assign o_in_stall = r_in_valid && !s1_fire;
    assign in_fire   = i_in_valid && !o_in_stall;

    itla_frame_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (s1_fire),
        .i_byte            (r_in_byte),
        .i_last            (r_in_last),
        .i_match_ethertype (r_match),
        .o_result          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= ETHERTYPE_IPV4;
        end else if (i_cfg_wr_en) begin
            r_match <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pkt_total <= '0;
            r_lat_total <= '0;
        end else if (s1_result) begin
            r_out_valid <= 1'b1;
            if (res.ok) begin
                r_pkt_total <= r_pkt_total + 64'd1;
                r_lat_total <= r_lat_total + {32'd0, res.stamp};
            end
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_result) begin
            r_out_ok  <= res.ok;
            r_out_lat <= res.ok ? res.stamp : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_accepted = r_out_ok;
    assign o_latency_value  = r_out_lat;
    assign o_packet_total   = r_pkt_total;
    assign o_latency_total  = r_lat_total;

`ifndef SYNTH
    a_totals_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> $stable(r_pkt_total) && $stable(r_lat_total))
        else $error("totals changed while result stalled");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_result |=> r_pkt_total == $past(r_pkt_total) + {63'd0, $past(res.ok)})
        else $error("packet total stepped wrong");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_lat == '0)
        else $error("rejected frame carries latency");

    a_stall_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_in_last && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked last byte");
`endif

endmodule
